### hdl/ddwpi_pkg.sv
// Shared types, constants and the microcode program of the wheel speed controller.
`timescale 1ns / 1ps

package ddwpi_pkg;

  // Defaults of the top level parameters.
  localparam int unsigned DEF_DRIVE_LIMIT     = 255;
  localparam int unsigned DEF_INTEGRATOR_BITS = 48;

  // Configuration port.
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN_LEFT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN_RIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN_LEFT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN_RIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_WHEEL_RADIUS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_BASE          = 3'd5;

  localparam logic [CFG_W-1:0] RST_PROP_GAIN     = 16'd4096;
  localparam logic [CFG_W-1:0] RST_INTEGRAL_GAIN = 16'd819;
  localparam logic [CFG_W-1:0] RST_INV_RADIUS    = 16'd5120;
  localparam logic [CFG_W-1:0] RST_WHEEL_BASE    = 16'd860;

  // Stream payload widths.
  localparam int unsigned IN_TDATA_W  = 128;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned PWM_W       = 9;

  // Datapath widths.
  localparam int unsigned MUL_A_W   = 36;
  localparam int unsigned MUL_B_W   = 24;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned BW_W      = 32;
  localparam int unsigned DES_W     = 35;
  localparam int unsigned EST_W     = 31;
  localparam int unsigned ANG_W     = 45;
  localparam int unsigned IERR_W    = 48;
  localparam int unsigned ACC_W     = 66;
  localparam int unsigned STEP_W    = 38;
  localparam int unsigned DRV_CALC_W = 40;
  localparam int unsigned INTEG_CALC_W = 65;

  // Fixed-point constants: 10 * pi/180 negated, pi/180 (Q8.24), and 0.1 s (Q0.16).
  localparam logic signed [MUL_B_W-1:0] K_NEG_DEG10 = -24'sd2928180;
  localparam logic signed [MUL_B_W-1:0] K_DEG       = 24'sd292818;
  localparam logic signed [MUL_B_W-1:0] K_TICK      = 24'sd6554;

  localparam logic signed [IERR_W:0] IERR_LIM = 49'sd1 <<< 46;
  localparam logic signed [ACC_W-1:0] STEP_RND = (66'sd1 <<< 28) - 66'sd1;

  // Sequencer.
  localparam int unsigned STEP_CNT_W = 5;
  localparam logic [STEP_CNT_W-1:0] SKIP_TARGET = 5'd2;
  localparam logic [STEP_CNT_W-1:0] LOOP_TARGET = 5'd4;
  localparam logic [STEP_CNT_W-1:0] NO_TARGET   = 5'd0;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_SKIP_CAPT,
    OP_CAPT,
    OP_MUL,
    OP_BW,
    OP_SUMW,
    OP_DES,
    OP_EST,
    OP_SUBA,
    OP_ANG,
    OP_INTEG,
    OP_ICLP,
    OP_IERR,
    OP_SUBE,
    OP_ACC_LD,
    OP_ACC_ADD,
    OP_ACC_HI,
    OP_STEP,
    OP_DRIVE,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    A_W,
    A_T,
    A_DELTA,
    A_DES,
    A_IERR_LO,
    A_IERR_HI
  } asel_e;

  typedef enum logic [2:0] {
    B_WB,
    B_IRAD,
    B_NEG_DEG10,
    B_DEG,
    B_TICK,
    B_PGAIN,
    B_IGAIN
  } bsel_e;

  typedef struct packed {
    op_e                   op;
    asel_e                 asel;
    bsel_e                 bsel;
    logic [STEP_CNT_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic prior_zero;
    logic wheel;
  } dp_stat_t;

  typedef struct packed {
    logic [CFG_W-1:0] prop_gain_left;
    logic [CFG_W-1:0] prop_gain_right;
    logic [CFG_W-1:0] integral_gain_left;
    logic [CFG_W-1:0] integral_gain_right;
    logic [CFG_W-1:0] inverse_wheel_radius;
    logic [CFG_W-1:0] wheel_base;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] linear_velocity;
    logic signed [15:0] angular_velocity;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic signed [15:0] left_delta;
    logic signed [15:0] right_delta;
  } in_item_t;

  function automatic ctrl_t cw(input op_e op, input asel_e a, input bsel_e b,
                               input logic [STEP_CNT_W-1:0] t);
    ctrl_t w;
    w.op     = op;
    w.asel   = a;
    w.bsel   = b;
    w.target = t;
    return w;
  endfunction

  // The program. Steps from LOOP_TARGET to the drive step run once per wheel.
  function automatic ctrl_t ucode_rom(input logic [STEP_CNT_W-1:0] step);
    ctrl_t w;
    unique case (step)
      5'd0:    w = cw(OP_SKIP_CAPT, A_W, B_WB, SKIP_TARGET);
      5'd1:    w = cw(OP_CAPT, A_W, B_WB, NO_TARGET);
      5'd2:    w = cw(OP_MUL, A_W, B_WB, NO_TARGET);
      5'd3:    w = cw(OP_BW, A_W, B_WB, NO_TARGET);
      5'd4:    w = cw(OP_SUMW, A_W, B_WB, NO_TARGET);
      5'd5:    w = cw(OP_MUL, A_T, B_IRAD, NO_TARGET);
      5'd6:    w = cw(OP_DES, A_W, B_WB, NO_TARGET);
      5'd7:    w = cw(OP_MUL, A_DELTA, B_NEG_DEG10, NO_TARGET);
      5'd8:    w = cw(OP_EST, A_W, B_WB, NO_TARGET);
      5'd9:    w = cw(OP_SUBA, A_W, B_WB, NO_TARGET);
      5'd10:   w = cw(OP_MUL, A_T, B_DEG, NO_TARGET);
      5'd11:   w = cw(OP_ANG, A_W, B_WB, NO_TARGET);
      5'd12:   w = cw(OP_MUL, A_DES, B_TICK, NO_TARGET);
      5'd13:   w = cw(OP_INTEG, A_W, B_WB, NO_TARGET);
      5'd14:   w = cw(OP_ICLP, A_W, B_WB, NO_TARGET);
      5'd15:   w = cw(OP_IERR, A_W, B_WB, NO_TARGET);
      5'd16:   w = cw(OP_SUBE, A_W, B_WB, NO_TARGET);
      5'd17:   w = cw(OP_MUL, A_T, B_PGAIN, NO_TARGET);
      5'd18:   w = cw(OP_ACC_LD, A_W, B_WB, NO_TARGET);
      5'd19:   w = cw(OP_MUL, A_IERR_LO, B_IGAIN, NO_TARGET);
      5'd20:   w = cw(OP_ACC_ADD, A_W, B_WB, NO_TARGET);
      5'd21:   w = cw(OP_MUL, A_IERR_HI, B_IGAIN, NO_TARGET);
      5'd22:   w = cw(OP_ACC_HI, A_W, B_WB, NO_TARGET);
      5'd23:   w = cw(OP_STEP, A_W, B_WB, NO_TARGET);
      5'd24:   w = cw(OP_DRIVE, A_W, B_WB, LOOP_TARGET);
      5'd25:   w = cw(OP_EMIT, A_W, B_WB, NO_TARGET);
      default: w = cw(OP_NOP, A_W, B_WB, NO_TARGET);
    endcase
    return w;
  endfunction

endpackage

### hdl/diff_drive_wheel_pi_controller.sv
// Top level of the differential-drive PI wheel speed controller.
//
//  Channel  Direction  Payload (low bit first)
//  s_axis   in         linear_velocity, angular_velocity, left_count, right_count,
//                      left_delta, right_delta
//  m_axis   out        left_pwm, right_pwm
//  cfg      in         write of one 16-bit register per beat, no read-back
//
// An item runs through the program one control word per cycle, save where the result
// is held at the last step, with every product going through the one shared 36 x 24
// multiplier in a step of its own; no new item is taken until the last one is done.
// Reset clears the drives, integrators and origins and loads the default gains and
// wheel geometry.
// The result sits in an output register; if it has not been taken when the next
// result is ready, the sequencer holds on its last step until it is.
`timescale 1ns / 1ps

module diff_drive_wheel_pi_controller #(
  parameter int unsigned DRIVE_LIMIT     = ddwpi_pkg::DEF_DRIVE_LIMIT,
  parameter int unsigned INTEGRATOR_BITS = ddwpi_pkg::DEF_INTEGRATOR_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // linear_velocity[15:0], angular_velocity[31:16], left_count[63:32],
  // right_count[95:64], left_delta[111:96], right_delta[127:112]
  input  logic [ddwpi_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // left_pwm[8:0], right_pwm[17:9], zeros above
  output logic [ddwpi_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [ddwpi_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ddwpi_pkg::CFG_W-1:0]         cfg_data_i
);
  import ddwpi_pkg::*;

  cfg_t        cfg_q;
  in_item_t    item;
  ctrl_t       ctrl;
  dp_stat_t    stat;
  logic        run;
  logic        start;
  logic        out_free;
  logic        emit;
  logic        out_vld_q;
  logic [PWM_W-1:0] left_pwm, right_pwm;
  logic [PWM_W-1:0] out_left_q, out_right_q;

  assign item.linear_velocity  = s_axis_tdata[15:0];
  assign item.angular_velocity = s_axis_tdata[31:16];
  assign item.left_count       = s_axis_tdata[63:32];
  assign item.right_count      = s_axis_tdata[95:64];
  assign item.left_delta       = s_axis_tdata[111:96];
  assign item.right_delta      = s_axis_tdata[127:112];

  assign s_axis_tready = !run;
  assign start         = s_axis_tvalid && !run;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign emit          = run && (ctrl.op == OP_EMIT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain_left       <= RST_PROP_GAIN;
      cfg_q.prop_gain_right      <= RST_PROP_GAIN;
      cfg_q.integral_gain_left   <= RST_INTEGRAL_GAIN;
      cfg_q.integral_gain_right  <= RST_INTEGRAL_GAIN;
      cfg_q.inverse_wheel_radius <= RST_INV_RADIUS;
      cfg_q.wheel_base           <= RST_WHEEL_BASE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROP_GAIN_LEFT:       cfg_q.prop_gain_left       <= cfg_data_i;
        CFG_PROP_GAIN_RIGHT:      cfg_q.prop_gain_right      <= cfg_data_i;
        CFG_INTEGRAL_GAIN_LEFT:   cfg_q.integral_gain_left   <= cfg_data_i;
        CFG_INTEGRAL_GAIN_RIGHT:  cfg_q.integral_gain_right  <= cfg_data_i;
        CFG_INVERSE_WHEEL_RADIUS: cfg_q.inverse_wheel_radius <= cfg_data_i;
        CFG_WHEEL_BASE:           cfg_q.wheel_base           <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ddwpi_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .out_free_i (out_free),
    .stat_i     (stat),
    .run_o      (run),
    .ctrl_o     (ctrl)
  );

  ddwpi_datapath #(
    .DriveLimit     (DRIVE_LIMIT),
    .IntegratorBits (INTEGRATOR_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (item),
    .cfg_i       (cfg_q),
    .run_i       (run),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .left_pwm_o  (left_pwm),
    .right_pwm_o (right_pwm)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_left_q  <= left_pwm;
      out_right_q <= right_pwm;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - 2 * PWM_W){1'b0}}, out_right_q, out_left_q};

endmodule

### hdl/ddwpi_sequencer.sv
// Step counter and microcode fetch with conditional jumps.
`timescale 1ns / 1ps

module ddwpi_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               out_free_i,
  input  ddwpi_pkg::dp_stat_t stat_i,
  output logic               run_o,
  output ddwpi_pkg::ctrl_t   ctrl_o
);
  import ddwpi_pkg::*;

  logic                  busy_q, busy_d;
  logic [STEP_CNT_W-1:0] step_q, step_d;
  ctrl_t                 ctrl;

  always_comb begin
    ctrl   = ucode_rom(step_q);
    busy_d = busy_q;
    step_d = step_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        step_d = '0;
      end
    end else begin
      unique case (ctrl.op)
        OP_SKIP_CAPT: begin
          step_d = stat_i.prior_zero ? step_q + 1'b1 : ctrl.target;
        end
        OP_DRIVE: begin
          // The first pass handles the left wheel, the second the right.
          step_d = stat_i.wheel ? step_q + 1'b1 : ctrl.target;
        end
        OP_EMIT: begin
          // Hold here until the output register can take the result.
          if (out_free_i) begin
            busy_d = 1'b0;
            step_d = '0;
          end
        end
        default: step_d = step_q + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  assign run_o  = busy_q;
  assign ctrl_o = ctrl;

endmodule

### hdl/ddwpi_datapath.sv
// Shared-multiplier datapath and controller state, driven by the control word.
`timescale 1ns / 1ps

module ddwpi_datapath #(
  parameter int unsigned DriveLimit     = ddwpi_pkg::DEF_DRIVE_LIMIT,
  parameter int unsigned IntegratorBits = ddwpi_pkg::DEF_INTEGRATOR_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  ddwpi_pkg::in_item_t            item_i,
  input  ddwpi_pkg::cfg_t                cfg_i,
  input  logic                           run_i,
  input  ddwpi_pkg::ctrl_t               ctrl_i,
  output ddwpi_pkg::dp_stat_t            stat_o,
  output logic [ddwpi_pkg::PWM_W-1:0]    left_pwm_o,
  output logic [ddwpi_pkg::PWM_W-1:0]    right_pwm_o
);
  import ddwpi_pkg::*;

  localparam int unsigned DrvW = $clog2(DriveLimit + 1) + 1;
  localparam int unsigned IntExtW = INTEG_CALC_W - IntegratorBits;
  localparam logic signed [DRV_CALC_W-1:0] DrvMax = DRV_CALC_W'(DriveLimit);
  localparam logic signed [DRV_CALC_W-1:0] DrvMin = -DrvMax;
  localparam logic signed [INTEG_CALC_W-1:0] IntMax =
    (65'sd1 <<< (IntegratorBits - 1)) - 65'sd1;
  localparam logic signed [INTEG_CALC_W-1:0] IntMin = -IntMax - 65'sd1;
  localparam logic signed [INTEG_CALC_W-1:0] ClpMax = 65'sd1 <<< 46;
  localparam logic signed [INTEG_CALC_W-1:0] ClpMin = -ClpMax;

  // Latched item.
  in_item_t item_q;

  // Controller state.
  logic signed [31:0]               org_l_q, org_r_q;
  logic signed [IntegratorBits-1:0] integ_l_q, integ_r_q;
  logic signed [DrvW-1:0]           drv_l_q, drv_r_q;
  logic                             prior_zero_q;
  logic                             wheel_q;

  // Working registers.
  logic signed [PROD_W-1:0]  p_q;
  logic signed [BW_W-1:0]    bw_q;
  logic signed [MUL_A_W-1:0] t_q;
  logic signed [DES_W-1:0]   des_q;
  logic signed [EST_W-1:0]   est_q;
  logic signed [ANG_W-1:0]   ang_q;
  logic signed [IERR_W-1:0]  ierr_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [STEP_W-1:0]  step_q;

  // Wheel-selected operands.
  logic signed [15:0]               delta_sel;
  logic signed [31:0]               cnt_sel, org_sel;
  logic signed [IntegratorBits-1:0] integ_sel;
  logic signed [DrvW-1:0]           drv_sel;
  logic [CFG_W-1:0]                 pgain_sel, igain_sel;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  logic signed [MUL_A_W-1:0]      vs, bw_ext, sumw, suba, sube;
  logic signed [PROD_W-1:0]       p_sh8, p_sh16, p_sh17;
  logic signed [INTEG_CALC_W-1:0] integ_ext, inc_ext, integ_sum, integ_sat, integ_clp;
  logic signed [IERR_W:0]         ierr_diff, ierr_clp;
  logic signed [ACC_W-1:0]        p_acc, acc_rnd, acc_sh;
  logic signed [DRV_CALC_W-1:0]   drv_ext, step_ext, drv_sum, drv_clp;
  logic signed [DRV_CALC_W-1:0]   drv_l_ext, drv_r_ext;

  always_comb begin
    delta_sel = wheel_q ? item_q.right_delta : item_q.left_delta;
    cnt_sel   = wheel_q ? item_q.right_count : item_q.left_count;
    org_sel   = wheel_q ? org_r_q : org_l_q;
    integ_sel = wheel_q ? integ_r_q : integ_l_q;
    drv_sel   = wheel_q ? drv_r_q : drv_l_q;
    pgain_sel = wheel_q ? cfg_i.prop_gain_right : cfg_i.prop_gain_left;
    igain_sel = wheel_q ? cfg_i.integral_gain_right : cfg_i.integral_gain_left;
  end

  always_comb begin
    case (ctrl_i.asel)
      A_W:       mul_a = {{20{item_q.angular_velocity[15]}}, item_q.angular_velocity};
      A_T:       mul_a = t_q;
      A_DELTA:   mul_a = {{20{delta_sel[15]}}, delta_sel};
      A_DES:     mul_a = {des_q[DES_W-1], des_q};
      A_IERR_LO: mul_a = {12'd0, ierr_q[23:0]};
      A_IERR_HI: mul_a = {{12{ierr_q[IERR_W-1]}}, ierr_q[IERR_W-1:24]};
      default:   mul_a = '0;
    endcase
    case (ctrl_i.bsel)
      B_WB:        mul_b = {8'd0, cfg_i.wheel_base};
      B_IRAD:      mul_b = {8'd0, cfg_i.inverse_wheel_radius};
      B_NEG_DEG10: mul_b = K_NEG_DEG10;
      B_DEG:       mul_b = K_DEG;
      B_TICK:      mul_b = K_TICK;
      B_PGAIN:     mul_b = {8'd0, pgain_sel};
      B_IGAIN:     mul_b = {8'd0, igain_sel};
      default:     mul_b = '0;
    endcase
  end

  always_comb begin
    // Wheel rate numerator: v << 13 minus (left) or plus (right) wheel_base * w.
    vs     = {{7{item_q.linear_velocity[15]}}, item_q.linear_velocity, 13'd0};
    bw_ext = {{4{bw_q[BW_W-1]}}, bw_q};
    sumw   = wheel_q ? vs + bw_ext : vs - bw_ext;
    suba   = {{4{org_sel[31]}}, org_sel} - {{4{cnt_sel[31]}}, cnt_sel};
    sube   = {des_q[DES_W-1], des_q} - {{5{est_q[EST_W-1]}}, est_q};

    p_sh8  = p_q >>> 8;
    p_sh16 = p_q >>> 16;
    p_sh17 = p_q >>> 17;

    // Saturating integrator.
    integ_ext = {{IntExtW{integ_sel[IntegratorBits-1]}}, integ_sel};
    inc_ext   = {{5{p_sh16[PROD_W-1]}}, p_sh16};
    integ_sum = integ_ext + inc_ext;
    if (integ_sum > IntMax) begin
      integ_sat = IntMax;
    end else if (integ_sum < IntMin) begin
      integ_sat = IntMin;
    end else begin
      integ_sat = integ_sum;
    end

    if (integ_ext > ClpMax) begin
      integ_clp = ClpMax;
    end else if (integ_ext < ClpMin) begin
      integ_clp = ClpMin;
    end else begin
      integ_clp = integ_ext;
    end

    ierr_diff = {ierr_q[IERR_W-1], ierr_q} - {{4{ang_q[ANG_W-1]}}, ang_q};
    if (ierr_diff > IERR_LIM) begin
      ierr_clp = IERR_LIM;
    end else if (ierr_diff < -IERR_LIM) begin
      ierr_clp = -IERR_LIM;
    end else begin
      ierr_clp = ierr_diff;
    end

    p_acc = {{(ACC_W-PROD_W){p_q[PROD_W-1]}}, p_q};

    // Shift toward zero: bias negative values before the arithmetic shift.
    acc_rnd = acc_q + (acc_q[ACC_W-1] ? STEP_RND : '0);
    acc_sh  = acc_rnd >>> 28;

    drv_ext  = {{(DRV_CALC_W-DrvW){drv_sel[DrvW-1]}}, drv_sel};
    step_ext = {{(DRV_CALC_W-STEP_W){step_q[STEP_W-1]}}, step_q};
    drv_sum  = wheel_q ? drv_ext - step_ext : drv_ext + step_ext;
    if (drv_sum > DrvMax) begin
      drv_clp = DrvMax;
    end else if (drv_sum < DrvMin) begin
      drv_clp = DrvMin;
    end else begin
      drv_clp = drv_sum;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      item_q <= item_i;
    end
    if (run_i) begin
      case (ctrl_i.op)
        OP_MUL:     p_q    <= mul_a * mul_b;
        OP_BW:      bw_q   <= p_q[BW_W-1:0];
        OP_SUMW:    t_q    <= sumw;
        OP_DES:     des_q  <= p_sh17[DES_W-1:0];
        OP_EST:     est_q  <= p_sh8[EST_W-1:0];
        OP_SUBA:    t_q    <= suba;
        OP_ANG:     ang_q  <= p_sh8[ANG_W-1:0];
        OP_ICLP:    ierr_q <= integ_clp[IERR_W-1:0];
        OP_IERR:    ierr_q <= ierr_clp[IERR_W-1:0];
        OP_SUBE:    t_q    <= sube;
        OP_ACC_LD:  acc_q  <= p_acc;
        OP_ACC_ADD: acc_q  <= acc_q + p_acc;
        OP_ACC_HI:  acc_q  <= acc_q + (p_acc <<< 24);
        OP_STEP:    step_q <= acc_sh[STEP_W-1:0];
        default:    ;
      endcase
    end
  end

  // Controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_l_q      <= '0;
      org_r_q      <= '0;
      integ_l_q    <= '0;
      integ_r_q    <= '0;
      drv_l_q      <= '0;
      drv_r_q      <= '0;
      prior_zero_q <= 1'b1;
      wheel_q      <= 1'b0;
    end else if (start_i) begin
      wheel_q <= 1'b0;
    end else if (run_i) begin
      case (ctrl_i.op)
        OP_CAPT: begin
          org_l_q <= item_q.left_count;
          org_r_q <= item_q.right_count;
        end
        OP_BW: begin
          prior_zero_q <= (item_q.left_count == 32'sd0);
        end
        OP_INTEG: begin
          if (wheel_q) begin
            integ_r_q <= integ_sat[IntegratorBits-1:0];
          end else begin
            integ_l_q <= integ_sat[IntegratorBits-1:0];
          end
        end
        OP_DRIVE: begin
          if (wheel_q) begin
            drv_r_q <= drv_clp[DrvW-1:0];
          end else begin
            drv_l_q <= drv_clp[DrvW-1:0];
            wheel_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign drv_l_ext = {{(DRV_CALC_W-DrvW){drv_l_q[DrvW-1]}}, drv_l_q};
  assign drv_r_ext = {{(DRV_CALC_W-DrvW){drv_r_q[DrvW-1]}}, drv_r_q};

  assign left_pwm_o  = drv_l_ext[PWM_W-1:0];
  assign right_pwm_o = drv_r_ext[PWM_W-1:0];

  assign stat_o.prior_zero = prior_zero_q;
  assign stat_o.wheel      = wheel_q;

endmodule

### verif/diff_drive_wheel_pi_controller_tb.sv
// Self-checking testbench for the differential-drive PI wheel speed controller.
`timescale 1ns / 1ps

module diff_drive_wheel_pi_controller_tb;
  import ddwpi_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned TICKS_PER_PHASE = 106;

  // Fixed-point constants of the control law: pi/180 in Q8.24 and 0.1 s in Q0.16.
  localparam longint DEG_Q24 = 292818;
  localparam longint TICK_Q16 = 6554;
  localparam longint IERR_MAX = longint'(1) <<< 46;
  localparam longint INTEG_MAX = (longint'(1) <<< (DEF_INTEGRATOR_BITS - 1)) - 1;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;
  localparam longint DRIVE_MAX = longint'(DEF_DRIVE_LIMIT);

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam cfg_t CFG_DEFAULT = '{RST_PROP_GAIN, RST_PROP_GAIN, RST_INTEGRAL_GAIN,
                                   RST_INTEGRAL_GAIN, RST_INV_RADIUS, RST_WHEEL_BASE};

  typedef struct packed {
    logic [PWM_W-1:0] left_pwm;
    logic [PWM_W-1:0] right_pwm;
  } pwm_pair_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_W-1:0]       cfg_data_i = '0;

  // Predictor state.
  cfg_t   gains_now = CFG_DEFAULT;
  longint left_drive = 0, right_drive = 0;
  longint left_integ = 0, right_integ = 0;
  longint left_origin = 0, right_origin = 0;
  bit     origin_armed = 1'b1;

  pwm_pair_t   pwm_expected[$];
  pwm_pair_t   pwm_head;
  int unsigned mismatches = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on = 1'b1;

  diff_drive_wheel_pi_controller uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clip(input longint x, input longint lim);
    return (x < -lim) ? -lim : ((x > lim) ? lim : x);
  endfunction

  // Truncated PI increment of one wheel; also advances that wheel's integrator.
  function automatic longint pi_increment(input longint desired, input longint delta,
                                          input longint count, input longint origin,
                                          inout longint integ, input longint pgain,
                                          input longint igain);
    longint est, angle, inc, ierr, sum;
    est   = (-delta * 10 * DEG_Q24) >>> 8;
    angle = ((origin - count) * DEG_Q24) >>> 8;
    inc   = (desired * TICK_Q16) >>> 16;
    if (inc > 0 && integ > INTEG_MAX - inc) begin
      integ = INTEG_MAX;
    end else if (inc < 0 && integ < INTEG_MIN - inc) begin
      integ = INTEG_MIN;
    end else begin
      integ = integ + inc;
    end
    ierr = clip(clip(integ, IERR_MAX) - angle, IERR_MAX);
    sum  = pgain * (desired - est) + igain * ierr;
    return (sum < 0) ? -((-sum) >>> 28) : (sum >>> 28);
  endfunction

  function automatic void predict_pwm(input in_item_t t);
    longint bw, vs, des_l, des_r, step_l, step_r;
    bw    = longint'(gains_now.wheel_base) * longint'(t.angular_velocity);
    vs    = longint'(t.linear_velocity) * 8192;
    des_l = ((vs - bw) * longint'(gains_now.inverse_wheel_radius)) >>> 17;
    des_r = ((vs + bw) * longint'(gains_now.inverse_wheel_radius)) >>> 17;
    // The origins follow the counts of the tick after a zero left reading.
    if (origin_armed) begin
      left_origin  = longint'(t.left_count);
      right_origin = longint'(t.right_count);
    end
    origin_armed = (t.left_count == 0);
    step_l = pi_increment(des_l, longint'(t.left_delta), longint'(t.left_count),
                          left_origin, left_integ,
                          longint'(gains_now.prop_gain_left),
                          longint'(gains_now.integral_gain_left));
    step_r = pi_increment(des_r, longint'(t.right_delta), longint'(t.right_count),
                          right_origin, right_integ,
                          longint'(gains_now.prop_gain_right),
                          longint'(gains_now.integral_gain_right));
    left_drive  = clip(left_drive + step_l, DRIVE_MAX);
    right_drive = clip(right_drive - step_r, DRIVE_MAX);
    pwm_expected.push_back('{left_pwm: left_drive[PWM_W-1:0],
                             right_pwm: right_drive[PWM_W-1:0]});
  endfunction

  function automatic int rand_span(input int a);
    return int'($urandom_range(0, 2 * a)) - a;
  endfunction

  function automatic logic [CFG_W-1:0] pick_reg(input logic [CFG_W-1:0] nominal);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return CFG_W'($urandom);
      default: return nominal - (nominal >> 2) + CFG_W'($urandom_range(0, nominal >> 1));
    endcase
  endfunction

  function automatic cfg_t random_gains();
    cfg_t c;
    c.prop_gain_left       = pick_reg(RST_PROP_GAIN);
    c.prop_gain_right      = pick_reg(RST_PROP_GAIN);
    c.integral_gain_left   = pick_reg(RST_INTEGRAL_GAIN);
    c.integral_gain_right  = pick_reg(RST_INTEGRAL_GAIN);
    c.inverse_wheel_radius = pick_reg(RST_INV_RADIUS);
    c.wheel_base           = pick_reg(RST_WHEEL_BASE);
    return c;
  endfunction

  task automatic send_tick(input logic signed [15:0] v, input logic signed [15:0] w,
                           input logic signed [31:0] lc, input logic signed [31:0] rc,
                           input logic signed [15:0] ld, input logic signed [15:0] rd);
    in_item_t t;
    t = '{v, w, lc, rc, ld, rd};
    if (idle_on && $urandom_range(0, 1) == 0) begin
      s_axis_tvalid <= 1'b0;
      do begin
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end while ($urandom_range(0, 1) == 0);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t.right_delta, t.left_delta, t.right_count, t.left_count,
                      t.angular_velocity, t.linear_velocity};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pwm(t);
  endtask

  // Stop sending and wait until every result has been taken.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pwm_expected.size() != 0) @(posedge clk_i);
  endtask

  // Writes every register index, the two unused ones included; those must be ignored.
  task automatic write_config(input cfg_t c);
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    drain();
    for (int k = 0; k < (1 << CFG_IDX_W); k++) begin
      idx = CFG_IDX_W'(k);
      case (idx)
        CFG_PROP_GAIN_LEFT:       val = c.prop_gain_left;
        CFG_PROP_GAIN_RIGHT:      val = c.prop_gain_right;
        CFG_INTEGRAL_GAIN_LEFT:   val = c.integral_gain_left;
        CFG_INTEGRAL_GAIN_RIGHT:  val = c.integral_gain_right;
        CFG_INVERSE_WHEEL_RADIUS: val = c.inverse_wheel_radius;
        CFG_WHEEL_BASE:           val = c.wheel_base;
        CFG_SPARE_LO, CFG_SPARE_HI: val = CFG_W'($urandom);
        default:                  val = '0;
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= val;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    gains_now = c;
  endtask

  task automatic test_reset_defaults();
    send_tick(16'sd0, 16'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0);
    // First nonzero reading after reset captures the origins.
    send_tick(16'sd4096, 16'sd0, 32'sd100, -32'sd100, -16'sd5, 16'sd5);
    send_tick(16'sd4096, 16'sd2048, 32'sd90, -32'sd90, -16'sd10, 16'sd10);
  endtask

  task automatic test_field_extremes();
    send_tick(16'sh7fff, 16'sh7fff, 32'sh7fff_ffff, 32'sh7fff_ffff, 16'sh7fff, 16'sh7fff);
    send_tick(16'sh8000, 16'sh8000, 32'sh8000_0000, 32'sh8000_0000, 16'sh8000, 16'sh8000);
    send_tick(16'sh7fff, 16'sh8000, 32'sh8000_0000, 32'sh7fff_ffff, 16'sh8000, 16'sh7fff);
    send_tick(-16'sd1, -16'sd1, -32'sd1, -32'sd1, -16'sd1, -16'sd1);
    send_tick(16'sh5555, 16'shaaaa, 32'sh5555_5555, 32'shaaaa_aaaa, 16'sh5555, 16'shaaaa);
    send_tick(16'shaaaa, 16'sh5555, 32'shaaaa_aaaa, 32'sh5555_5555, 16'shaaaa, 16'sh5555);
  endtask

  task automatic test_origin_recapture();
    send_tick(16'sd2048, 16'sd0, 32'sd0, 32'sd500, 16'sd0, 16'sd0);
    send_tick(16'sd2048, 16'sd0, 32'sd7000, -32'sd7000, 16'sd3, -16'sd3);
    send_tick(16'sd2048, 16'sd0, 32'sd6990, -32'sd6990, -16'sd10, 16'sd10);
    send_tick(16'sd0, 16'sd4096, 32'sd0, 32'sd123, 16'sd0, 16'sd0);
  endtask

  task automatic test_drive_saturation();
    cfg_t c;
    c = CFG_DEFAULT;
    c.prop_gain_left  = '1;
    c.prop_gain_right = '1;
    write_config(c);
    send_tick(16'sh7fff, 16'sd0, 32'sd10, 32'sd10, 16'sd0, 16'sd0);
    send_tick(16'sh7fff, 16'sd0, 32'sd10, 32'sd10, 16'sd0, 16'sd0);
    send_tick(16'sh8000, 16'sd0, 32'sd10, 32'sd10, 16'sd0, 16'sd0);
    send_tick(16'sh8000, 16'sd0, 32'sd10, 32'sd10, 16'sd0, 16'sd0);
    send_tick(16'sh8000, 16'sh7fff, 32'sd10, 32'sd10, 16'sd0, 16'sd0);
  endtask

  task automatic test_config_extremes();
    write_config('0);
    send_tick(16'sd4096, 16'sd4096, 32'sd50, -32'sd50, 16'sd20, -16'sd20);
    send_tick(16'sh8000, 16'sh7fff, 32'sd60, -32'sd60, 16'sd30, -16'sd30);
    write_config('1);
    send_tick(16'sd4096, 16'sh8000, 32'sd70, -32'sd70, -16'sd20, 16'sd20);
    send_tick(16'sh7fff, 16'sh7fff, 32'sh8000_0000, 32'sh7fff_ffff, 16'sh8000, 16'sh7fff);
  endtask

  // Mostly consistent encoder tracks under moderate commands, with zero left
  // readings and fully random ticks mixed in.
  task automatic test_random_ticks();
    int unsigned       kind;
    logic signed [15:0] v, w, ld, rd;
    logic signed [31:0] l_pos, r_pos;
    l_pos = $urandom;
    r_pos = $urandom;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_config(phase == 0 ? CFG_DEFAULT : random_gains());
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if (n % 20 == 0) idle_on = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
        kind = $urandom_range(0, 99);
        if (kind < 82) begin
          ld = 16'(rand_span(40));
          rd = 16'(rand_span(40));
          l_pos += 32'(ld);
          r_pos += 32'(rd);
          v = 16'(rand_span(8192));
          w = 16'(rand_span(12288));
        end else if (kind < 85) begin
          ld = '0;
          rd = 16'(rand_span(40));
          l_pos = '0;
          r_pos += 32'(rd);
          v = 16'(rand_span(4096));
          w = 16'(rand_span(4096));
        end else begin
          v = 16'($urandom);
          w = 16'($urandom);
          l_pos = $urandom;
          r_pos = $urandom;
          ld = 16'($urandom);
          rd = 16'($urandom);
        end
        send_tick(v, w, l_pos, r_pos, ld, rd);
      end
    end
  endtask

  // Result checker and output backpressure.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pwm_expected.size() == 0) begin
        $error("unexpected result beat: left_pwm %0d, right_pwm %0d",
               $signed(m_axis_tdata[PWM_W-1:0]), $signed(m_axis_tdata[2*PWM_W-1:PWM_W]));
        mismatches++;
      end else begin
        pwm_head = pwm_expected.pop_front();
        if (m_axis_tdata[PWM_W-1:0] !== pwm_head.left_pwm) begin
          $error("left_pwm: expected %0d, actual %0d", $signed(pwm_head.left_pwm),
                 $signed(m_axis_tdata[PWM_W-1:0]));
          mismatches++;
        end
        if (m_axis_tdata[2*PWM_W-1:PWM_W] !== pwm_head.right_pwm) begin
          $error("right_pwm: expected %0d, actual %0d", $signed(pwm_head.right_pwm),
                 $signed(m_axis_tdata[2*PWM_W-1:PWM_W]));
          mismatches++;
        end
      end
    end
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left    <= $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Ends the run when nothing has moved on any port for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_field_extremes();
    test_origin_recapture();
    test_drive_saturation();
    test_config_extremes();
    test_random_ticks();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
